// ===== hdl/rtp_pkg.sv =====
package rtp_pkg;

    localparam int END_W   = 13;
    localparam int VAL_W   = 64;
    localparam int RADIX_W = 6;

    // configuration register indexes
    localparam logic REG_RADIX       = 1'b0;
    localparam logic REG_PREFIX_MODE = 1'b1;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_O_LO  = 8'h6f;
    localparam logic [7:0] CH_H_LO  = 8'h68;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_Z_UP  = 8'h5a;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_LO  = 8'h7a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] UP_OFS   = 8'd55;
    localparam logic [7:0] LO_OFS   = 8'd87;

    // classified character
    typedef struct packed {
        logic [5:0] dval;
        logic       dinv;
        logic       is_space;
        logic       is_minus;
        logic       is_plus;
        logic       is_zero;
        logic       is_x_any;
        logic       is_x_lo;
        logic       is_b;
        logic       is_o;
        logic       is_hash;
        logic       is_h;
        logic       is_nul;
    } t_cls;

    typedef struct packed {
        t_cls cls;
        logic last;
    } t_qitem;

    localparam t_cls CLS_NUL = '{dval: 6'd0, dinv: 1'b1, is_nul: 1'b1, default: 1'b0};

    // engine phases
    localparam logic [2:0] PH_WS     = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // prefix selection codes
    localparam logic [2:0] SEL_START = 3'd0;
    localparam logic [2:0] SEL_ZERO  = 3'd1;
    localparam logic [2:0] SEL_MAIN  = 3'd2;
    localparam logic [2:0] SEL_HEX   = 3'd3;
    localparam logic [2:0] SEL_OPEN  = 3'd4;

    // digit status codes
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_DIG  = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

endpackage

// ===== hdl/rtp_front.sv =====
module rtp_front (
    input  logic             i_valid,
    input  logic [7:0]       i_char_code,
    input  logic             i_last,
    input  logic             i_q_full,
    output logic             o_stall,
    output logic             o_push,
    output rtp_pkg::t_qitem  o_item
);

    rtp_pkg::t_cls cls;
    logic [7:0]    c;

    always_comb begin
        c = i_char_code;
        cls = '0;
        cls.dinv = 1'b1;
        if (c >= rtp_pkg::CH_ZERO && c <= rtp_pkg::CH_NINE) begin
            cls.dval = 6'(c - rtp_pkg::CH_ZERO);
            cls.dinv = 1'b0;
        end else if (c >= rtp_pkg::CH_A_UP && c <= rtp_pkg::CH_Z_UP) begin
            cls.dval = 6'(c - rtp_pkg::UP_OFS);
            cls.dinv = 1'b0;
        end else if (c >= rtp_pkg::CH_A_LO && c <= rtp_pkg::CH_Z_LO) begin
            cls.dval = 6'(c - rtp_pkg::LO_OFS);
            cls.dinv = 1'b0;
        end
        cls.is_space = (c == rtp_pkg::CH_SPACE) || (c >= rtp_pkg::CH_TAB && c <= rtp_pkg::CH_CR);
        cls.is_minus = (c == rtp_pkg::CH_MINUS);
        cls.is_plus  = (c == rtp_pkg::CH_PLUS);
        cls.is_zero  = (c == rtp_pkg::CH_ZERO);
        cls.is_x_lo  = (c == rtp_pkg::CH_X_LO);
        cls.is_x_any = (c == rtp_pkg::CH_X_LO) || (c == rtp_pkg::CH_X_UP);
        cls.is_b     = (c == rtp_pkg::CH_B_LO);
        cls.is_o     = (c == rtp_pkg::CH_O_LO);
        cls.is_hash  = (c == rtp_pkg::CH_HASH);
        cls.is_h     = (c == rtp_pkg::CH_H_LO);
        cls.is_nul   = (c == rtp_pkg::CH_NUL);
    end

    assign o_stall     = i_q_full;
    assign o_push      = i_valid && !i_q_full;
    assign o_item.cls  = cls;
    assign o_item.last = i_last;

endmodule

// ===== hdl/rtp_queue.sv =====
module rtp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rtp_pkg::t_qitem  i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output rtp_pkg::t_qitem  o_item
);

    rtp_pkg::t_qitem r_mem [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd];

endmodule

// ===== hdl/rtp_back.sv =====
module rtp_back #(
    parameter int MAX_LEN    = 4096,
    parameter int VALUE_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [rtp_pkg::RADIX_W-1:0]  i_radix,
    input  logic                         i_prefix_mode,
    input  logic                         i_q_valid,
    input  rtp_pkg::t_qitem              i_q_item,
    output logic                         o_pop,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [rtp_pkg::VAL_W-1:0]    o_value,
    output logic                         o_converted,
    output logic                         o_overflow,
    output logic [rtp_pkg::END_W-1:0]    o_end_position
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int VB = VALUE_BITS;
    localparam int PRW = VB + 7;
    localparam logic [VB-1:0] HALF = {1'b1, {(VB-1){1'b0}}};
    localparam logic [PW-1:0] MAXP = PW'(MAX_LEN);

    typedef struct packed {
        logic [2:0]    ph;
        logic          neg;
        logic [5:0]    base;
        logic [1:0]    st;
        logic [VB-1:0] acc;
        logic [PW-1:0] mark;
    } t_eng;

    function automatic t_eng eng_init(logic [5:0] base);
        t_eng e;
        e = '0;
        e.ph = rtp_pkg::PH_WS;
        e.base = base;
        return e;
    endfunction

    function automatic t_eng eng_digit(t_eng ein, rtp_pkg::t_cls k, logic [PW-1:0] pos);
        t_eng           e;
        logic [5:0]     b;
        logic [PRW-1:0] prod;
        logic [VB-1:0]  lim;
        e = ein;
        b = (e.base == 6'd0) ? 6'd10 : e.base;
        prod = PRW'(e.acc) * PRW'(b) + PRW'(k.dval);
        lim = e.neg ? HALF : HALF - 1'b1;
        if (k.dinv || k.dval >= b) begin
            e.mark = (e.st != rtp_pkg::ST_NONE) ? pos : '0;
            e.ph = rtp_pkg::PH_DONE;
        end else if (e.st == rtp_pkg::ST_OVF || prod > PRW'(lim)) begin
            e.st = rtp_pkg::ST_OVF;
        end else begin
            e.st = rtp_pkg::ST_DIG;
            e.acc = prod[VB-1:0];
        end
        return e;
    endfunction

    function automatic t_eng eng_step(t_eng ein, rtp_pkg::t_cls k, logic [PW-1:0] pos);
        t_eng e;
        logic first;
        e = ein;
        first = 1'b0;
        case (e.ph)
            rtp_pkg::PH_WS: begin
                if (k.is_minus) begin
                    e.neg = 1'b1;
                    e.ph = rtp_pkg::PH_SIGNED;
                end else if (k.is_plus) begin
                    e.ph = rtp_pkg::PH_SIGNED;
                end else if (!k.is_space) begin
                    first = 1'b1;
                end
            end
            rtp_pkg::PH_SIGNED: begin
                first = 1'b1;
            end
            rtp_pkg::PH_ZERO: begin
                e.ph = rtp_pkg::PH_DIGITS;
                if (k.is_x_any) begin
                    e.base = 6'd16;
                end else begin
                    if (e.base == 6'd0) begin
                        e.base = 6'd8;
                    end
                    // the leading zero counts as a digit
                    e.st = rtp_pkg::ST_DIG;
                    e = eng_digit(e, k, pos);
                end
            end
            rtp_pkg::PH_DIGITS: begin
                e = eng_digit(e, k, pos);
            end
            default: begin
            end
        endcase
        if (first) begin
            if ((e.base == 6'd0 || e.base == 6'd16) && k.is_zero) begin
                e.ph = rtp_pkg::PH_ZERO;
            end else begin
                if (e.base == 6'd0) begin
                    e.base = 6'd10;
                end
                e.ph = rtp_pkg::PH_DIGITS;
                e = eng_digit(e, k, pos);
            end
        end
        return e;
    endfunction

    t_eng          r_main, r_hex, n_main, n_hex, c_main, c_hex;
    logic [PW-1:0] r_pos, n_pos, c_pos;
    logic          r_pend_h, n_pend_h, c_pend_h;
    logic          r_busy, n_busy;
    logic          r_ended, n_ended, c_ended;
    logic          r_cur_prefix, c_cur_prefix;
    logic [2:0]    r_sel, n_sel, c_sel;
    logic          feed_both;
    t_eng          sel_e;
    logic          use_hex;
    logic [VB-1:0] res_val;

    logic                      r_out_valid;
    logic [rtp_pkg::VAL_W-1:0] r_value;
    logic                      r_converted;
    logic                      r_overflow;
    logic [rtp_pkg::END_W-1:0] r_end;

    rtp_pkg::t_cls k;
    logic          out_free;

    assign k        = i_q_item.cls;
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_q_valid && (!i_q_item.last || out_free);

    always_comb begin
        if (r_busy) begin
            c_main       = r_main;
            c_hex        = r_hex;
            c_pos        = r_pos;
            c_pend_h     = r_pend_h;
            c_ended      = r_ended;
            c_sel        = r_sel;
            c_cur_prefix = r_cur_prefix;
        end else begin
            c_main       = eng_init(i_prefix_mode ? 6'd10 : i_radix);
            c_hex        = eng_init(6'd16);
            c_pos        = '0;
            c_pend_h     = 1'b0;
            c_ended      = 1'b0;
            c_sel        = rtp_pkg::SEL_START;
            c_cur_prefix = i_prefix_mode;
        end

        n_main   = c_main;
        n_hex    = c_hex;
        n_pend_h = c_pend_h;
        n_ended  = c_ended;
        n_sel    = c_sel;
        feed_both = 1'b0;

        if (!c_ended) begin
            if (c_pos >= MAXP || k.is_nul) begin
                n_main  = eng_step(c_main, rtp_pkg::CLS_NUL, c_pos);
                n_hex   = eng_step(c_hex, rtp_pkg::CLS_NUL, c_pos);
                n_ended = 1'b1;
            end else begin
                n_pend_h = k.is_h;
                if (c_cur_prefix) begin
                    feed_both = 1'b1;
                    case (c_sel)
                        rtp_pkg::SEL_START: begin
                            if (k.is_hash) begin
                                n_main = eng_init(6'd16);
                                n_sel = rtp_pkg::SEL_MAIN;
                                feed_both = 1'b0;
                            end else begin
                                n_sel = k.is_zero ? rtp_pkg::SEL_ZERO : rtp_pkg::SEL_OPEN;
                            end
                        end
                        rtp_pkg::SEL_ZERO: begin
                            if (k.is_b) begin
                                n_main = eng_init(6'd2);
                                n_sel = rtp_pkg::SEL_MAIN;
                                feed_both = 1'b0;
                            end else if (k.is_o) begin
                                n_main = eng_init(6'd8);
                                n_sel = rtp_pkg::SEL_MAIN;
                                feed_both = 1'b0;
                            end else begin
                                n_sel = k.is_x_lo ? rtp_pkg::SEL_HEX : rtp_pkg::SEL_OPEN;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (feed_both) begin
                        n_main = eng_step(c_main, k, c_pos);
                        n_hex  = eng_step(c_hex, k, c_pos);
                    end
                end else begin
                    n_main = eng_step(c_main, k, c_pos);
                end
            end
        end

        n_pos = (c_pos < MAXP) ? c_pos + 1'b1 : c_pos;

        // end of string without a terminator
        if (i_q_item.last && !n_ended) begin
            n_main  = eng_step(n_main, rtp_pkg::CLS_NUL, n_pos);
            n_hex   = eng_step(n_hex, rtp_pkg::CLS_NUL, n_pos);
            n_ended = 1'b1;
        end
        n_busy = !i_q_item.last;

        use_hex = c_cur_prefix && ((n_sel == rtp_pkg::SEL_HEX) ||
                  (n_sel != rtp_pkg::SEL_MAIN && n_pos != '0 && n_pend_h));
        sel_e = use_hex ? n_hex : n_main;
        if (sel_e.st == rtp_pkg::ST_OVF) begin
            res_val = sel_e.neg ? HALF : HALF - 1'b1;
        end else begin
            res_val = sel_e.neg ? ('0 - sel_e.acc) : sel_e.acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_main       <= n_main;
            r_hex        <= n_hex;
            r_pos        <= n_pos;
            r_pend_h     <= n_pend_h;
            r_ended      <= n_ended;
            r_sel        <= n_sel;
            r_cur_prefix <= c_cur_prefix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_q_item.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_item.last) begin
            r_value     <= rtp_pkg::VAL_W'($signed(res_val));
            r_converted <= (sel_e.st != rtp_pkg::ST_NONE);
            r_overflow  <= (sel_e.st == rtp_pkg::ST_OVF);
            r_end       <= rtp_pkg::END_W'(sel_e.mark);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_value        = r_value;
    assign o_converted    = r_converted;
    assign o_overflow     = r_overflow;
    assign o_end_position = r_end;

endmodule

// ===== hdl/radix_integer_text_parser_unit.sv =====
// radix_integer_text_parser_unit
// parses a signed integer from a text string fed one character per transaction
// input channel: i_valid / o_stall with i_char_code and i_last; i_last marks the
//   final character of a string and each string gives exactly one result
// output channel: o_valid / i_stall with o_value (64-bit two's complement, sign
//   extended from VALUE_BITS, saturated on overflow), o_converted, o_overflow and
//   o_end_position (first unconsumed character, 0 when nothing converted)
// configuration: i_cfg_we / i_cfg_index / i_cfg_data write radix (index 0, 0 means
//   automatic octal / decimal / hex) and prefix_mode (index 1); the values are
//   sampled at the first character of each string
// throughput: one character per cycle unless a final character waits on a stalled
//   result; each digit engine in the back end does one multiply-by-base and add
// result: o_valid is registered and rises at the edge that pops the last character
// reset: radix 0, plain mode, queue empty, no string in progress, no result
// stall: a held result keeps o_valid and its payload; non-final characters keep
//   flowing, a final character waits at the head of the two-entry queue until the
//   output register frees up, and o_stall rises once the queue fills
module radix_integer_text_parser_unit #(
    parameter int MAX_LEN    = 4096,
    parameter int VALUE_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [rtp_pkg::RADIX_W-1:0]  i_cfg_data,
    // character channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_char_code,
    input  logic                         i_last,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [rtp_pkg::VAL_W-1:0]    o_value,
    output logic                         o_converted,
    output logic                         o_overflow,
    output logic [rtp_pkg::END_W-1:0]    o_end_position
);

    logic [rtp_pkg::RADIX_W-1:0] r_radix;
    logic                        r_prefix_mode;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix       <= '0;
            r_prefix_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rtp_pkg::REG_RADIX:       r_radix <= i_cfg_data;
                rtp_pkg::REG_PREFIX_MODE: r_prefix_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    rtp_pkg::t_qitem push_item;
    rtp_pkg::t_qitem head_item;
    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            pop;

    // front end: classify each character
    rtp_front u_front (
        .i_valid     (i_valid),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_item      (push_item)
    );

    // short queue decoupling front and back
    rtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    // back end: sign, prefix selection, digit engines and result register
    rtp_back #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_radix        (r_radix),
        .i_prefix_mode  (r_prefix_mode),
        .i_q_valid      (q_valid),
        .i_q_item       (head_item),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_value        (o_value),
        .o_converted    (o_converted),
        .o_overflow     (o_overflow),
        .o_end_position (o_end_position)
    );

endmodule
